// ===== rtl/rbc_pkg.sv =====
// Shared types, constants and round functions of the Raiden block cipher.
// No dependencies; every rtl module imports this package.
package rbc_pkg;

   localparam int ROUNDS     = 16;
   localparam int STAGES     = 2 * ROUNDS;
   localparam int RND_IDX_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam int KEY_WORDS  = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int SHIFT_LEFT  = 9;
   localparam int SHIFT_RIGHT = 14;

   localparam logic [1:0] REG_KEY_WORD0 = 2'd0;
   localparam logic [1:0] REG_KEY_WORD1 = 2'd1;
   localparam logic [1:0] REG_KEY_WORD2 = 2'd2;
   localparam logic [1:0] REG_KEY_WORD3 = 2'd3;

   typedef logic [31:0] word_type;
   typedef logic [ROUNDS-1:0][31:0] subkey_array_type;
   typedef logic [KEY_WORDS-1:0][31:0] key_array_type;

   typedef struct packed {
      logic     operation;
      word_type block_word0;
      word_type block_word1;
      logic     last_block;
   } req_payload_type;

   typedef struct packed {
      word_type result_word0;
      word_type result_word1;
      logic     last_out;
   } rsp_payload_type;

   // Block state as it moves down the round pipeline.
   typedef struct packed {
      logic     operation;
      word_type b0;
      word_type b1;
      logic     last;
   } stage_type;

   typedef enum logic [1:0] {
      KS_IDLE,
      KS_LOAD,
      KS_RUN
   } ks_state_type;

   function automatic word_type mix(word_type s, word_type x);
      word_type a;
      word_type d;
      a = s + x;
      d = s - x;
      return (a << SHIFT_LEFT) ^ d ^ (a >> SHIFT_RIGHT);
   endfunction

   function automatic word_type next_subkey(key_array_type w);
      return (w[0] + w[1]) + ((w[2] + w[3]) ^ (w[0] << w[2][4:0]));
   endfunction

endpackage

// ===== rtl/rbc_half_round.sv =====
// One pipeline stage of the cipher: half of a Raiden round, encrypt or decrypt.
// Depends on rbc_pkg.
module rbc_half_round (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 odd_half,
   input  logic                 in_valid,
   input  rbc_pkg::stage_type   in_stage,
   input  rbc_pkg::word_type    enc_subkey,
   input  rbc_pkg::word_type    dec_subkey,
   output logic                 out_valid,
   output rbc_pkg::stage_type   out_stage
);
   import rbc_pkg::*;

   logic      valid_ff;
   stage_type stage_ff;
   stage_type stage_in;
   logic      target_b0;
   word_type  subkey;
   word_type  target;
   word_type  other;
   word_type  f;
   word_type  updated;

   // Encrypt updates b0 then b1; decrypt undoes b1 then b0.
   always_comb begin
      target_b0 = ~(in_stage.operation ^ odd_half);
      subkey    = in_stage.operation ? dec_subkey : enc_subkey;
      target    = target_b0 ? in_stage.b0 : in_stage.b1;
      other     = target_b0 ? in_stage.b1 : in_stage.b0;
      f         = mix(subkey, other);
      updated   = in_stage.operation ? (target - f) : (target + f);
      stage_in  = in_stage;
      if (target_b0) begin
         stage_in.b0 = updated;
      end else begin
         stage_in.b1 = updated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== rtl/rbc_key_sched.sv =====
// Key registers on the APB-style port and the subkey schedule, one subkey a cycle.
// Depends on rbc_pkg.
module rbc_key_sched (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rbc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [rbc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [rbc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output logic                                keys_ready,
   output rbc_pkg::subkey_array_type           subkeys
);
   import rbc_pkg::*;

   key_array_type              key_ff;
   key_array_type              key_in;
   key_array_type              w_ff;
   key_array_type              w_in;
   subkey_array_type           sub_ff;
   subkey_array_type           sub_in;
   ks_state_type               state_ff;
   ks_state_type               state_in;
   logic [RND_IDX_W-1:0]       cnt_ff;
   logic [RND_IDX_W-1:0]       cnt_in;
   logic                       wr_en;
   logic [1:0]                 reg_idx;
   logic [1:0]                 w_idx;
   word_type                   v;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      unique case (reg_idx)
         REG_KEY_WORD0: csr_prdata = key_ff[0];
         REG_KEY_WORD1: csr_prdata = key_ff[1];
         REG_KEY_WORD2: csr_prdata = key_ff[2];
         REG_KEY_WORD3: csr_prdata = key_ff[3];
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      key_in = key_ff;
      if (wr_en) begin
         key_in[reg_idx] = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign v     = next_subkey(w_ff);
   assign w_idx = 2'(cnt_ff);

   // Any key write restarts the schedule from the new key.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      w_in     = w_ff;
      sub_in   = sub_ff;
      unique case (state_ff)
         KS_IDLE: begin
         end
         KS_LOAD: begin
            w_in     = key_ff;
            cnt_in   = '0;
            state_in = KS_RUN;
         end
         KS_RUN: begin
            w_in[w_idx]    = v;
            sub_in[cnt_ff] = v;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == RND_IDX_W'(ROUNDS - 1)) begin
               state_in = KS_IDLE;
            end
         end
         default: state_in = KS_LOAD;
      endcase
      if (wr_en) begin
         state_in = KS_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KS_LOAD;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      sub_ff <= sub_in;
   end

   assign keys_ready = (state_ff == KS_IDLE);
   assign subkeys    = sub_ff;

endmodule

// ===== rtl/raiden_block_cipher.sv =====
// Raiden block cipher, 16 rounds, one half-round per pipeline stage.
// An accepted input beat moves down the half-round stage registers to the result beat.
// Throughput: one block per cycle while the subkeys are ready; a stalled result holds the whole pipeline.
// Reset, and each key write, reload the subkey schedule, with req_stall held high
// until it is done. Key registers reset to zero. Depends on rbc_pkg.
module raiden_block_cipher (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rbc_pkg::req_payload_type          req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rbc_pkg::rsp_payload_type          rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rbc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rbc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rbc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import rbc_pkg::*;

   logic              advance;
   logic              keys_ready;
   subkey_array_type  subkeys;
   logic [STAGES:0]   stage_valid;
   stage_type         stage_data [STAGES+1];

   rbc_key_sched u_key_sched (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .keys_ready  (keys_ready),
      .subkeys     (subkeys)
   );

   assign advance   = ~(rsp_valid & rsp_stall);
   assign req_stall = ~advance | ~keys_ready;

   assign stage_valid[0]          = req_valid & ~req_stall;
   assign stage_data[0].operation = req_data.operation;
   assign stage_data[0].b0        = req_data.block_word0;
   assign stage_data[0].b1        = req_data.block_word1;
   assign stage_data[0].last      = req_data.last_block;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      // Encrypt round r uses subkey r; decrypt walks the schedule backwards.
      rbc_half_round u_half_round (
         .clock      (clock),
         .reset      (reset),
         .enable     (advance),
         .odd_half   (1'(k % 2)),
         .in_valid   (stage_valid[k]),
         .in_stage   (stage_data[k]),
         .enc_subkey (subkeys[k / 2]),
         .dec_subkey (subkeys[ROUNDS - 1 - k / 2]),
         .out_valid  (stage_valid[k+1]),
         .out_stage  (stage_data[k+1])
      );
   end

   assign rsp_valid             = stage_valid[STAGES];
   assign rsp_data.result_word0 = stage_data[STAGES].b0;
   assign rsp_data.result_word1 = stage_data[STAGES].b1;
   assign rsp_data.last_out     = stage_data[STAGES].last;

endmodule
